// ===== hw/rtl/dtwp_pkg.sv =====
// Package for the depth to world point core: image and grid constants,
// configuration register indexes and reset values, and shared types.
// No dependencies.
package dtwp_pkg;

    localparam int SUBSAMPLE_STEP = 8;
    localparam int IMAGE_WIDTH    = 640;
    localparam int IMAGE_HEIGHT   = 480;

    localparam int DEPTH_LIMIT = 5000;
    localparam int DEPTH_W     = 13;
    localparam int COORD_W     = 13;

    localparam int GRID_SHIFT = 26;
    localparam longint GRID_RECIP_L =
        ((longint'(1) << GRID_SHIFT) + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP;
    localparam logic [GRID_SHIFT:0] GRID_RECIP = (GRID_SHIFT + 1)'(GRID_RECIP_L);

    localparam int LAST_X = ((IMAGE_WIDTH - 1) / SUBSAMPLE_STEP) * SUBSAMPLE_STEP;
    localparam int LAST_Y = ((IMAGE_HEIGHT - 1) / SUBSAMPLE_STEP) * SUBSAMPLE_STEP;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int PIPE_STAGES = 6;

    localparam logic [47:0] ROT_ROW0_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_ROW2_RESET = 48'h4000_0000_0000;

    typedef enum logic [2:0] {
        REG_ROT_ROW0        = 3'd0,
        REG_ROT_ROW1        = 3'd1,
        REG_ROT_ROW2        = 3'd2,
        REG_CENTER_X        = 3'd3,
        REG_CENTER_Y        = 3'd4,
        REG_CENTER_Z        = 3'd5,
        REG_PRINCIPAL_POINT = 3'd6,
        REG_INVERSE_FOCAL   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [47:0]        rot_row0;
        logic [47:0]        rot_row1;
        logic [47:0]        rot_row2;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [31:0]        principal_point;
        logic [47:0]        inverse_focal;
    } dtwp_cfg_t;

    typedef struct packed {
        logic [9:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [DEPTH_W-1:0] depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               point_valid;
        logic               last_of_frame;
    } dtwp_item_t;

    typedef struct packed {
        logic       valid;
        logic       point_valid;
        logic       last_of_frame;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } dtwp_ctrl_t;

    // A coordinate is a multiple of the step when the fraction part of its
    // product with the scaled reciprocal stays below that reciprocal.
    function automatic logic on_grid(input logic [11:0] v);
        logic [GRID_SHIFT+12:0] prod;
        prod = (GRID_SHIFT + 13)'(v) * (GRID_SHIFT + 13)'(GRID_RECIP);
        return {1'b0, prod[GRID_SHIFT-1:0]} < GRID_RECIP;
    endfunction

endpackage

// ===== hw/rtl/dtwp_front.sv =====
// Front end of the depth to world point core: accepts pixels, drops those off
// the grid or outside the image, and classifies depth and frame end.
// Depends on dtwp_pkg.
module dtwp_front
    import dtwp_pkg::*;
(
    input  logic       start,
    input  logic       busy,
    input  logic [9:0] pixel_x,
    input  logic [8:0] pixel_y,
    input  logic [15:0] depth_mm,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       push,
    output dtwp_item_t push_item
);

    logic in_image;
    logic grid_hit;
    logic depth_ok;
    logic is_last;

    assign in_image = ({3'b000, pixel_x} < COORD_W'(IMAGE_WIDTH))
                   && ({4'b0000, pixel_y} < COORD_W'(IMAGE_HEIGHT));
    assign grid_hit = on_grid({2'b00, pixel_x}) && on_grid({3'b000, pixel_y});
    assign depth_ok = (depth_mm != 16'd0) && (depth_mm < 16'(DEPTH_LIMIT));
    assign is_last  = ({3'b000, pixel_x} == COORD_W'(LAST_X))
                   && ({4'b0000, pixel_y} == COORD_W'(LAST_Y));

    assign push = start && !busy && in_image && grid_hit;

    always_comb
    begin
        push_item.pixel_x       = pixel_x;
        push_item.pixel_y       = pixel_y;
        push_item.depth         = depth_mm[DEPTH_W-1:0];
        push_item.red           = red;
        push_item.green         = green;
        push_item.blue          = blue;
        push_item.point_valid   = depth_ok;
        push_item.last_of_frame = is_last;
    end

endmodule

// ===== hw/rtl/dtwp_queue.sv =====
// Short queue between the front end and the arithmetic back end.
// The head is popped in every cycle in which the queue holds an entry.
// Depends on dtwp_pkg.
module dtwp_queue
    import dtwp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dtwp_item_t push_item,
    output logic       full,
    output logic       pop_valid,
    output dtwp_item_t pop_item
);

    dtwp_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("Transaction pushed into a full queue.");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("Queue count did not follow a push.");

endmodule

// ===== hw/rtl/dtwp_back.sv =====
// Arithmetic back end: pinhole back-projection, rotation into the world
// frame, rounding and saturation, in a six-stage pipeline.
// Depends on dtwp_pkg.
module dtwp_back
    import dtwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dtwp_cfg_t          cfg,
    input  logic               in_valid,
    input  dtwp_item_t         in_item,
    output logic               done,
    output logic               point_valid,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic               last_of_frame
);

    dtwp_ctrl_t         ctrl_reg [PIPE_STAGES];
    dtwp_ctrl_t         ctrl_next [PIPE_STAGES];

    logic signed [17:0] off_x, off_y;
    logic signed [DEPTH_W:0] depth_s;
    logic signed [24:0] ifx_s, ify_s;

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic [DEPTH_W+3:0] zc1_reg, zc1_next, zc2_reg, zc2_next;
    logic signed [56:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [56:0] qx_rnd, qy_rnd;
    logic signed [31:0] cam_reg [3];
    logic signed [31:0] cam_next [3];
    logic signed [15:0] rot [3][3];
    logic signed [31:0] center [3];
    logic signed [47:0] prod_reg [3][3];
    logic signed [47:0] prod_next [3][3];
    logic signed [49:0] acc_reg [3];
    logic signed [49:0] acc_next [3];
    logic signed [49:0] acc_rnd [3];
    logic signed [35:0] scaled [3];
    logic signed [31:0] sat [3];
    logic signed [31:0] world_reg [3];
    logic signed [31:0] world_next [3];

    assign off_x   = $signed({4'b0000, in_item.pixel_x, 4'b0000})
                   - $signed({2'b00, cfg.principal_point[15:0]});
    assign off_y   = $signed({5'b00000, in_item.pixel_y, 4'b0000})
                   - $signed({2'b00, cfg.principal_point[31:16]});
    assign depth_s = $signed({1'b0, in_item.depth});
    assign ifx_s   = $signed({1'b0, cfg.inverse_focal[23:0]});
    assign ify_s   = $signed({1'b0, cfg.inverse_focal[47:24]});

    assign px_next  = off_x * depth_s;
    assign py_next  = off_y * depth_s;
    assign zc1_next = {in_item.depth, 4'b0000};
    assign qx_next  = px_reg * ifx_s;
    assign qy_next  = py_reg * ify_s;
    assign zc2_next = zc1_reg;
    assign qx_rnd   = qx_reg + 57'sd8388608;
    assign qy_rnd   = qy_reg + 57'sd8388608;

    always_comb
    begin
        ctrl_next[0].valid         = in_valid;
        ctrl_next[0].point_valid   = in_item.point_valid;
        ctrl_next[0].last_of_frame = in_item.last_of_frame;
        ctrl_next[0].red           = in_item.red;
        ctrl_next[0].green         = in_item.green;
        ctrl_next[0].blue          = in_item.blue;
        for (int s = 1; s < PIPE_STAGES; s++)
        begin
            ctrl_next[s] = ctrl_reg[s-1];
        end

        cam_next[0] = qx_rnd[55:24];
        cam_next[1] = qy_rnd[55:24];
        cam_next[2] = $signed({15'b0, zc2_reg});

        center[0] = cfg.center_x;
        center[1] = cfg.center_y;
        center[2] = cfg.center_z;
        for (int k = 0; k < 3; k++)
        begin
            rot[0][k] = $signed(cfg.rot_row0[16*k +: 16]);
            rot[1][k] = $signed(cfg.rot_row1[16*k +: 16]);
            rot[2][k] = $signed(cfg.rot_row2[16*k +: 16]);
        end

        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[r][k] = rot[r][k] * cam_reg[k];
            end
            acc_next[r] = 50'(prod_reg[r][0]) + 50'(prod_reg[r][1])
                        + 50'(prod_reg[r][2]) + (50'(center[r]) <<< 14);
            acc_rnd[r]  = acc_reg[r] + 50'sd8192;
            scaled[r]   = acc_rnd[r][49:14];
            if (scaled[r][35:31] == 5'b00000 || scaled[r][35:31] == 5'b11111)
            begin
                sat[r] = scaled[r][31:0];
            end
            else
            begin
                sat[r] = scaled[r][35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            world_next[r] = ctrl_reg[PIPE_STAGES-2].point_valid ? sat[r] : 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                ctrl_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                ctrl_reg[s] <= ctrl_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        zc1_reg <= zc1_next;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        zc2_reg <= zc2_next;
        for (int r = 0; r < 3; r++)
        begin
            cam_reg[r]   <= cam_next[r];
            acc_reg[r]   <= acc_next[r];
            world_reg[r] <= world_next[r];
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[r][k] <= prod_next[r][k];
            end
        end
    end

    assign done          = ctrl_reg[PIPE_STAGES-1].valid;
    assign point_valid   = ctrl_reg[PIPE_STAGES-1].point_valid;
    assign last_of_frame = ctrl_reg[PIPE_STAGES-1].last_of_frame;
    assign out_red       = point_valid ? ctrl_reg[PIPE_STAGES-1].red : 8'd0;
    assign out_green     = point_valid ? ctrl_reg[PIPE_STAGES-1].green : 8'd0;
    assign out_blue      = point_valid ? ctrl_reg[PIPE_STAGES-1].blue : 8'd0;
    assign world_x       = world_reg[0];
    assign world_y       = world_reg[1];
    assign world_z       = world_reg[2];

    assert property (@(posedge clk) disable iff (!rst_n) in_valid |-> ##6 done)
        else $error("Transaction entering the pipeline was not delivered.");
    assert property (@(posedge clk) disable iff (!rst_n) !in_valid |-> ##6 !done)
        else $error("Result delivered without a matching transaction.");
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !point_valid |-> world_x == 32'sd0 && world_y == 32'sd0
                                 && world_z == 32'sd0)
        else $error("Invalid point carries nonzero coordinates.");

endmodule

// ===== hw/rtl/depth_to_world_point_core.sv =====
// Depth to world point core: a pixel is accepted when start is high and busy
// is low; a grid pixel gives one result, strobed by done once it has passed
// through the queue and the back-end pipeline. Throughput is one pixel per
// clock, set by the fully pipelined multipliers; the receiver cannot stall,
// so the queue never fills. rst_n clears the queue and the pipeline control
// at once and loads the reset values of the configuration registers.
// Depends on dtwp_pkg, dtwp_front, dtwp_queue and dtwp_back.
module depth_to_world_point_core
    import dtwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         pixel_x,
    input  logic [8:0]         pixel_y,
    input  logic [15:0]        depth_mm,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    output logic               done,
    output logic               point_valid,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic               last_of_frame
);

    dtwp_cfg_t  cfg_reg, cfg_next;
    logic       push;
    dtwp_item_t push_item;
    logic       pop_valid;
    dtwp_item_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROT_ROW0:        cfg_next.rot_row0 = cfg_data;
                REG_ROT_ROW1:        cfg_next.rot_row1 = cfg_data;
                REG_ROT_ROW2:        cfg_next.rot_row2 = cfg_data;
                REG_CENTER_X:        cfg_next.center_x = $signed(cfg_data[31:0]);
                REG_CENTER_Y:        cfg_next.center_y = $signed(cfg_data[31:0]);
                REG_CENTER_Z:        cfg_next.center_z = $signed(cfg_data[31:0]);
                REG_PRINCIPAL_POINT: cfg_next.principal_point = cfg_data[31:0];
                REG_INVERSE_FOCAL:   cfg_next.inverse_focal = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_row0        <= ROT_ROW0_RESET;
            cfg_reg.rot_row1        <= ROT_ROW1_RESET;
            cfg_reg.rot_row2        <= ROT_ROW2_RESET;
            cfg_reg.center_x        <= '0;
            cfg_reg.center_y        <= '0;
            cfg_reg.center_z        <= '0;
            cfg_reg.principal_point <= '0;
            cfg_reg.inverse_focal   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dtwp_front u_front (
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .depth_mm  (depth_mm),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .push      (push),
        .push_item (push_item)
    );

    dtwp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (busy),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    dtwp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (pop_valid),
        .in_item       (pop_item),
        .done          (done),
        .point_valid   (point_valid),
        .world_x       (world_x),
        .world_y       (world_y),
        .world_z       (world_z),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .last_of_frame (last_of_frame)
    );

endmodule
